// File: sv/pftbl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pftbl_pkg;

    // Defaults for the top-level parameters
    localparam int FLOW_COUNT_DEF    = 1024;
    localparam int FRACTION_BITS_DEF = 16;

    // Field widths
    localparam int OP_W      = 2;
    localparam int FLOW_W    = 10;
    localparam int AMT_W     = 16;
    localparam int TOK_W     = 16;
    localparam int CAP_W     = 16;
    localparam int RATE_W    = 32;
    localparam int TIME_W    = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;

    // Operation codes
    typedef logic [OP_W-1:0] t_op;
    localparam t_op OP_TICK    = 2'd0;
    localparam t_op OP_CONSUME = 2'd1;
    localparam t_op OP_RESTORE = 2'd2;

    // Register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_CAPACITY = 1'd0;
    localparam t_cfg_idx CFG_REFILL   = 1'd1;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 16'd16;
    localparam logic [RATE_W-1:0] RATE_RESET = 32'd65536;

    // Controller to datapath
    typedef struct packed {
        logic clear_wr;
        logic tick;
        logic restore;
        logic load;
        logic mul;
        logic commit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// File: sv/pftbl_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pftbl_in_if;
    import pftbl_pkg::*;

    logic              valid;
    logic              ready;
    t_op               operation;
    logic [FLOW_W-1:0] flow_index;
    logic [AMT_W-1:0]  request_amount;

    modport source (output valid, operation, flow_index, request_amount, input ready);
    modport sink   (input valid, operation, flow_index, request_amount, output ready);
    modport monitor(input valid, ready, operation, flow_index, request_amount);
endinterface

`default_nettype wire

// File: sv/pftbl_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pftbl_out_if;
    import pftbl_pkg::*;

    logic             valid;
    logic             ready;
    logic             granted;
    logic [TOK_W-1:0] tokens_left;

    modport source (output valid, granted, tokens_left, input ready);
    modport sink   (input valid, granted, tokens_left, output ready);
    modport monitor(input valid, ready, granted, tokens_left);
endinterface

`default_nettype wire

// File: sv/pftbl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pftbl_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  pftbl_pkg::t_op     i_op,
    input  pftbl_pkg::t_status i_status,
    output logic               o_in_ready,
    output pftbl_pkg::t_cmd    o_cmd
);
    import pftbl_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_MUL   = 2'd2;
    localparam logic [1:0] ST_WB    = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Clear the table after reset, then sequence one word at a time; a consume goes through read, multiply, write back
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_op)
                        OP_TICK:    o_cmd.tick = 1'b1;
                        OP_RESTORE: o_cmd.restore = 1'b1;
                        OP_CONSUME: begin
                            o_cmd.load = 1'b1;
                            n_state    = ST_MUL;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_WB;
            end
            ST_WB: begin
                // Hold until the output register can take the result
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// File: sv/pftbl_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module pftbl_dp #(
    parameter int FLOW_COUNT    = pftbl_pkg::FLOW_COUNT_DEF,
    parameter int FRACTION_BITS = pftbl_pkg::FRACTION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  pftbl_pkg::t_cfg_idx           i_cfg_index,
    input  logic [pftbl_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  pftbl_pkg::t_cmd               i_cmd,
    input  logic [pftbl_pkg::FLOW_W-1:0]  i_flow_index,
    input  logic [pftbl_pkg::AMT_W-1:0]   i_request_amount,
    input  logic                          i_out_ready,
    output pftbl_pkg::t_status            o_status,
    output logic                          o_out_valid,
    output logic                          o_out_granted,
    output logic [pftbl_pkg::TOK_W-1:0]   o_out_tokens_left
);
    import pftbl_pkg::*;

    localparam int IDX_W  = (FLOW_COUNT > 1) ? $clog2(FLOW_COUNT) : 1;
    localparam int LVL_W  = TOK_W + FRACTION_BITS;
    localparam int ROW_W  = 1 + LVL_W + TIME_W;
    localparam int PROD_W = TIME_W + RATE_W;

    // Reduce a flow index modulo the table depth by descending subtracts
    function automatic logic [FLOW_W-1:0] f_slot(input logic [FLOW_W-1:0] v);
        logic [FLOW_W-1:0] r;
        r = v;
        for (int k = FLOW_W - 1; k >= 0; k--) begin
            if ((FLOW_COUNT << k) < (1 << FLOW_W)) begin
                if (r >= FLOW_W'(FLOW_COUNT << k)) begin
                    r = r - FLOW_W'(FLOW_COUNT << k);
                end
            end
        end
        return r;
    endfunction

    // Table row: {valid, level, last refill time}
    logic [ROW_W-1:0]  r_table [FLOW_COUNT];
    logic [ROW_W-1:0]  r_rd;

    logic [CAP_W-1:0]  r_cap;
    logic [RATE_W-1:0] r_rate;
    logic [TIME_W-1:0] r_time;
    logic [IDX_W-1:0]  r_clr_idx;

    logic [IDX_W-1:0]  r_slot;
    logic [AMT_W-1:0]  r_req;
    logic [LVL_W-1:0]  r_lvl;
    logic [LVL_W-1:0]  r_room;
    logic              r_over;
    logic              r_fresh;
    logic [PROD_W-1:0] r_product;

    logic              r_out_valid;
    logic              r_out_granted;
    logic [TOK_W-1:0]  r_out_tokens;

    logic [IDX_W-1:0]  in_slot;
    logic [LVL_W-1:0]  cap_lvl;
    logic              rd_valid;
    logic [LVL_W-1:0]  rd_level;
    logic [TIME_W-1:0] rd_time;
    logic [LVL_W-1:0]  start_lvl;
    logic [TIME_W-1:0] elapsed;
    logic              sat;
    logic [LVL_W-1:0]  refilled;
    logic [LVL_W-1:0]  need;
    logic              grant;
    logic [LVL_W-1:0]  new_lvl;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [ROW_W-1:0]  wr_data;

    assign in_slot = IDX_W'(f_slot(i_flow_index));
    assign cap_lvl = {r_cap, {FRACTION_BITS{1'b0}}};

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= CAP_RESET;
            r_rate <= RATE_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_CAPACITY: r_cap  <= i_cfg_wdata[CAP_W-1:0];
                CFG_REFILL:   r_rate <= i_cfg_wdata[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance time; sweep the valid bits after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time    <= '0;
            r_clr_idx <= '0;
        end else begin
            if (i_cmd.tick) begin
                r_time <= r_time + 1'b1;
            end
            if (i_cmd.clear_wr) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    // Table write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_slot;
        wr_data = '0;
        if (i_cmd.clear_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_idx;
        end else if (i_cmd.restore) begin
            wr_en   = 1'b1;
            wr_addr = in_slot;
        end else if (i_cmd.commit && !(r_fresh && (r_req == '0))) begin
            wr_en   = 1'b1;
            wr_data = {1'b1, new_lvl, r_time};
        end
    end

    // Table storage with registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[wr_addr] <= wr_data;
        end
        if (i_cmd.load) begin
            r_rd <= r_table[in_slot];
        end
    end

    // Latch the request with the read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_slot <= in_slot;
            r_req  <= i_request_amount;
        end
    end

    // Multiply stage: an untouched bucket starts full with no elapsed time
    assign rd_valid  = r_rd[ROW_W-1];
    assign rd_level  = r_rd[TIME_W +: LVL_W];
    assign rd_time   = r_rd[TIME_W-1:0];
    assign start_lvl = rd_valid ? rd_level : cap_lvl;
    assign elapsed   = rd_valid ? (r_time - rd_time) : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_lvl     <= start_lvl;
            r_over    <= (start_lvl >= cap_lvl);
            r_room    <= cap_lvl - start_lvl;
            r_fresh   <= !rd_valid;
            r_product <= {{RATE_W{1'b0}}, elapsed} * {{TIME_W{1'b0}}, r_rate};
        end
    end

    // Write-back stage: saturate the refill, then take the request if it fits
    assign sat      = r_over || (r_product >= PROD_W'(r_room));
    assign refilled = sat ? cap_lvl : (r_lvl + r_product[LVL_W-1:0]);
    assign need     = {r_req, {FRACTION_BITS{1'b0}}};
    assign grant    = (refilled >= need);
    assign new_lvl  = grant ? (refilled - need) : refilled;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_granted <= grant;
            r_out_tokens  <= new_lvl[LVL_W-1 -: TOK_W];
        end
    end

    assign o_status.clear_last = (r_clr_idx == IDX_W'(FLOW_COUNT - 1));
    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid         = r_out_valid;
    assign o_out_granted       = r_out_granted;
    assign o_out_tokens_left   = r_out_tokens;

endmodule

`default_nettype wire

// File: sv/per_flow_token_bucket_limiter.sv
// Per-flow token bucket limiter: one bucket per flow in a single-port table,
// levels in unsigned fixed point with FRACTION_BITS fraction bits. A tick word
// or a restore word is done in the idle state; a consume word goes through
// table read, refill multiply, and write back and result, and its result may
// wait in write back for the output register to drain. These steps are set
// by the one read-modify-write of the bucket table and its single 32x32 multiplier.
// The next word is accepted while a result is still held in the output
// register. After reset a clearing pass over all FLOW_COUNT rows (1024 by
// default) clears every valid bit, so every bucket reads as full; no word is
// accepted during it, while configuration writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none

module per_flow_token_bucket_limiter #(
    parameter int FLOW_COUNT    = pftbl_pkg::FLOW_COUNT_DEF,
    parameter int FRACTION_BITS = pftbl_pkg::FRACTION_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  pftbl_pkg::t_cfg_idx         i_cfg_index,
    input  logic [pftbl_pkg::CFG_W-1:0] i_cfg_wdata,
    pftbl_in_if.sink                    in_chan,
    pftbl_out_if.source                 out_chan
);
    import pftbl_pkg::*;

    t_cmd    cmd;
    t_status status;

    pftbl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_chan.valid),
        .i_op       (in_chan.operation),
        .i_status   (status),
        .o_in_ready (in_chan.ready),
        .o_cmd      (cmd)
    );

    pftbl_dp #(
        .FLOW_COUNT    (FLOW_COUNT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_cmd             (cmd),
        .i_flow_index      (in_chan.flow_index),
        .i_request_amount  (in_chan.request_amount),
        .i_out_ready       (out_chan.ready),
        .o_status          (status),
        .o_out_valid       (out_chan.valid),
        .o_out_granted     (out_chan.granted),
        .o_out_tokens_left (out_chan.tokens_left)
    );

endmodule

`default_nettype wire

// File: sv/pftbl_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module pftbl_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input pftbl_pkg::t_op              i_in_op,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_out_granted,
    input logic [pftbl_pkg::TOK_W-1:0] i_out_tokens_left
);
    import pftbl_pkg::*;

    // The clearing pass follows every reset: no word is taken right after it
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input ready right after reset");

    // A consume keeps the block busy on the next cycle
    a_consume_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_op == OP_CONSUME))
        |=> !i_in_ready)
        else $error("input ready while a consume is in flight");

    // A new result only comes out of the write-back step
    a_result_from_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared without a write-back step");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_out_granted) && $stable(i_out_tokens_left)))
        else $error("stalled result changed or dropped");

endmodule

bind per_flow_token_bucket_limiter pftbl_chk u_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (in_chan.valid),
    .i_in_ready        (in_chan.ready),
    .i_in_op           (in_chan.operation),
    .i_out_valid       (out_chan.valid),
    .i_out_ready       (out_chan.ready),
    .i_out_granted     (out_chan.granted),
    .i_out_tokens_left (out_chan.tokens_left)
);

`default_nettype wire
